[rtl/asa_pkg.sv]
// ----------------------------------------------------------------------------
// ADC sample averager package
// Widths, constants, register indexes and the request types that are shared
// by the serial divider, the serial multiplier and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package asa_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 8;
  localparam int VREF_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIVD_W     = 21;
  localparam int DIVS_W     = 10;
  localparam int DIV_CNT_W  = 5;
  localparam int MUL_A_W    = 10;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = 4;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd21;
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 4'd10;

  localparam logic [CNT_W-1:0]  SUPPLY_SAMPLES   = 8'd10;
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 8'd1;
  localparam logic [VREF_W-1:0] VREF_RST         = 16'd5000;
  localparam logic [VREF_W-1:0] MIN_VREF_MV      = 16'd2000;
  // Full scale of the converter times the bandgap voltage: 1024 * 1100.
  localparam logic [DIVD_W-1:0] SUPPLY_NUM       = 21'd1126400;
  localparam logic [OUT_W-1:0]  OUT_MAX          = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VREF_MV      = 2'd2;

  localparam logic MODE_READ   = 1'b0;
  localparam logic MODE_SUPPLY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } asa_div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } asa_mul_req_t;

endpackage

`default_nettype wire

[rtl/asa_div.sv]
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; the result is valid with the
// done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire asa_pkg::asa_div_req_t         req,
  output logic [asa_pkg::DIVD_W-1:0]         quotient,
  output logic                               done
);
  import asa_pkg::*;

  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVS_W:0]      rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      rem_nxt = ge ? DIVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

[rtl/asa_mul.sv]
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Retires one bit of the narrow operand per cycle; the product is valid
// with the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire asa_pkg::asa_mul_req_t         req,
  output logic [asa_pkg::PROD_W-1:0]         product,
  output logic                               done
);
  import asa_pkg::*;

  logic [MUL_B_W:0]     hi_r, hi_nxt;
  logic [MUL_A_W-1:0]   lo_r, lo_nxt;
  logic [MUL_B_W-1:0]   b_r, b_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_B_W:0]     add;

  assign add = hi_r + (lo_r[0] ? {1'b0, b_r} : '0);

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      hi_nxt   = '0;
      lo_nxt   = req.a;
      b_nxt    = req.b;
      cnt_nxt  = MUL_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = {1'b0, add[MUL_B_W:1]};
      lo_nxt  = {add[0], lo_r[MUL_A_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign product = {hi_r[MUL_B_W-1:0], lo_r};
  assign done    = done_r;

endmodule

`default_nettype wire

[rtl/adc_sample_average_scaler_top.sv]
// ----------------------------------------------------------------------------
// ADC sample averager and scaler
// Sums raw converter samples and turns each average into millivolts, or into
// the supply voltage when the samples come from the bandgap reference.
//
// Samples arrive on the in_ channel (valid/ready); a transaction that does
// not complete an average leaves the block ready for the next sample. The
// transaction completing an average starts a serial divider (one quotient
// bit per cycle). In read mode a serial multiplier then scales the average
// by vref_mv. In supply mode, unless the average is zero, the divider runs
// again, dividing the bandgap constant by the average. No sample is taken
// while this runs. Results leave on the out_ channel from an output
// register; a finished result waits in a holding register while the
// receiver stalls, and sampling resumes as soon as the output register is
// free. Configuration writes to mode, sample_count and vref_mv discard any
// partly gathered average. Synchronous reset restores mode 0, sample_count
// 1, vref_mv 5000 and an empty accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_sample_average_scaler_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [asa_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [asa_pkg::OUT_W-1:0]             out_value_mv,
  output logic                                  out_status,
  input  wire logic                             cfg_we,
  input  wire logic [asa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [asa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import asa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_AVG  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SUP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [CNT_W-1:0]  scount_r, scount_nxt;
  logic [VREF_W-1:0] vref_r, vref_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OUT_W-1:0]  res_value_r, res_value_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_value_r, out_value_nxt;
  logic              out_status_r, out_status_nxt;

  asa_div_req_t      div_req;
  asa_mul_req_t      mul_req;
  logic [DIVD_W-1:0] div_quo;
  logic              div_done;
  logic [PROD_W-1:0] mul_prod;
  logic              mul_done;

  logic [CNT_W-1:0]  target;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  cnt_add;
  logic              in_acc;
  logic [DIVS_W-1:0] avg;
  logic              out_free;

  asa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .quotient (div_quo),
    .done     (div_done)
  );

  asa_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .product (mul_prod),
    .done    (mul_done)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign target   = (mode_r == MODE_SUPPLY) ? SUPPLY_SAMPLES : scount_r;
  assign sum_add  = sum_r + SUM_W'(in_sample);
  assign cnt_add  = cnt_r + 1'b1;
  assign avg      = div_quo[DIVS_W-1:0];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    scount_nxt     = scount_r;
    vref_nxt       = vref_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    div_req        = '0;
    mul_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_add >= target) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVD_W'(sum_add);
            div_req.divisor  = DIVS_W'(target);
            sum_nxt          = '0;
            cnt_nxt          = '0;
            state_nxt        = S_AVG;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_add;
          end
        end
      end
      S_AVG: begin
        if (div_done) begin
          if (mode_r == MODE_READ) begin
            mul_req.start = 1'b1;
            mul_req.a     = avg;
            mul_req.b     = vref_r;
            state_nxt     = S_MUL;
          end else if (avg == '0) begin
            res_value_nxt  = OUT_MAX;
            res_status_nxt = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = SUPPLY_NUM;
            div_req.divisor  = avg;
            state_nxt        = S_SUP;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          res_value_nxt  = mul_prod[PROD_W-1:MUL_A_W];
          res_status_nxt = 1'b0;
          state_nxt      = S_DONE;
        end
      end
      S_SUP: begin
        if (div_done) begin
          if (div_quo[DIVD_W-1:OUT_W] != '0) begin
            res_value_nxt  = OUT_MAX;
            res_status_nxt = 1'b1;
          end else begin
            res_value_nxt  = div_quo[OUT_W-1:0];
            res_status_nxt = 1'b0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_MODE: begin
          mode_nxt = cfg_wdata[0];
          sum_nxt  = '0;
          cnt_nxt  = '0;
        end
        REG_SAMPLE_COUNT: begin
          if (cfg_wdata[CNT_W-1:0] != '0) begin
            scount_nxt = cfg_wdata[CNT_W-1:0];
          end
          sum_nxt = '0;
          cnt_nxt = '0;
        end
        REG_VREF_MV: begin
          if (cfg_wdata[VREF_W-1:0] >= MIN_VREF_MV) begin
            vref_nxt = cfg_wdata[VREF_W-1:0];
          end
          sum_nxt = '0;
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_READ;
      scount_r    <= SAMPLE_COUNT_RST;
      vref_r      <= VREF_RST;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      scount_r    <= scount_nxt;
      vref_r      <= vref_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value_mv = out_value_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

[rtl/asa_checker.sv]
// ----------------------------------------------------------------------------
// ADC sample averager port checker
// Watches the top-level ports for reset behaviour, result holding under
// stall, status versus saturated value and no result right after a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [asa_pkg::OUT_W-1:0]      out_value_mv,
  input wire logic                           out_status
);
  import asa_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result channel valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_mv) && $stable(out_status))
    else $error("Stalled result transaction changed.");

  a_status_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_value_mv == OUT_MAX)
    else $error("Status set without a saturated value.");

  a_no_sample_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("Result issued straight after a sample transaction.");

endmodule

bind adc_sample_average_scaler_top asa_checker u_asa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value_mv (out_value_mv),
  .out_status   (out_status)
);

`default_nettype wire
